// File: rtl/core/barometric_pressure_compensation_unit_assert.svh
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_UNIT_ASSERT_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BPC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define BPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/bpc_pkg.sv
package bpc_pkg;

	typedef struct packed {
		logic [15:0] raw_temperature;
		logic [23:0] raw_pressure;
	} in_t;

	typedef struct packed {
		logic signed [16:0] temperature_tenths;
		logic [17:0]        pressure_pa;
		logic               divide_fault;
	} out_t;

	typedef enum logic [1:0] {
		REG_PCOEF_A = 2'd0,
		REG_TCOEF   = 2'd1,
		REG_PCOEF_B = 2'd2,
		REG_OSS     = 2'd3
	} cfg_reg_t;

	localparam int B6_OFFSET = 4000;
	localparam int X3_OFFSET = 32768;
	localparam int P_SCALE   = 50000;
	localparam int K_SQ      = 3038;
	localparam int K_LIN     = 7357;
	localparam int K_OFS     = 3791;
	localparam int T_MAX     = 65535;
	localparam int T_MIN     = -65536;
	localparam int P_MAX     = 262143;

	// first divider: |MC*2048| over |X1+MD|
	localparam int DIV1_W  = 27;
	localparam int DIV1_DW = 18;
	// second divider: B7 (or 2*B7) over B4
	localparam int DIV2_W  = 32;
	localparam int DIV2_DW = 17;

	typedef struct packed {
		logic signed [16:0] t;
		logic               fault;
		logic [18:0]        up;
	} side_t;

	typedef struct packed {
		logic [DIV1_DW:0]   rem;
		logic [DIV1_W-1:0]  quo;
		logic [DIV1_DW-1:0] dvs;
		logic               neg;
		logic signed [17:0] x1;
		side_t              sd;
	} div1_t;

	typedef struct packed {
		logic [DIV2_DW:0]   rem;
		logic [DIV2_W-1:0]  quo;
		logic [DIV2_DW-1:0] dvs;
		logic               dbl;
		side_t              sd;
	} div2_t;

	// signed divide by 2**k, truncating toward zero
	function automatic logic signed [63:0] trunc_shr(input logic signed [63:0] a,
		input logic [5:0] k);
		logic signed [63:0] bias;
		bias = a[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
		return (a + bias) >>> k;
	endfunction

	// one restoring step: shift in next dividend bit, emit one quotient bit
	function automatic div1_t div1_step(input div1_t s);
		div1_t            r;
		logic [DIV1_DW:0] tr;
		r  = s;
		tr = {s.rem[DIV1_DW-1:0], s.quo[DIV1_W-1]};
		if (tr >= {1'b0, s.dvs}) begin
			r.rem = tr - {1'b0, s.dvs};
			r.quo = {s.quo[DIV1_W-2:0], 1'b1};
		end else begin
			r.rem = tr;
			r.quo = {s.quo[DIV1_W-2:0], 1'b0};
		end
		return r;
	endfunction

	function automatic div2_t div2_step(input div2_t s);
		div2_t            r;
		logic [DIV2_DW:0] tr;
		r  = s;
		tr = {s.rem[DIV2_DW-1:0], s.quo[DIV2_W-1]};
		if (tr >= {1'b0, s.dvs}) begin
			r.rem = tr - {1'b0, s.dvs};
			r.quo = {s.quo[DIV2_W-2:0], 1'b1};
		end else begin
			r.rem = tr;
			r.quo = {s.quo[DIV2_W-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

// File: rtl/core/barometric_pressure_compensation_unit.sv
// Compensates one raw temperature word and one raw 24-bit pressure reading per item
// into temperature in 0.1 C and pressure in Pa, using the calibration words in the
// four config registers (write them only while no item is in flight). One item is
// accepted every cycle while the output is not stalled. The pipeline holds the two
// restoring dividers, which produce one quotient bit per stage (27 stages
// for the temperature term, 32 for the pressure quotient). A stalled output freezes
// the whole pipeline. A zero divisor gives divide_fault with zero results.
`include "barometric_pressure_compensation_unit_assert.svh"

module barometric_pressure_compensation_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  bpc_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output bpc_pkg::out_t out_data,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [63:0]   cfg_data
);
	import bpc_pkg::*;

	logic [63:0] pca_q, tc_q;
	logic [31:0] pcb_q;
	logic [1:0]  oss_q;

	logic signed [15:0] ac1, ac2, ac3, mc, md, b1, b2;
	logic [15:0]        ac4, ac5, ac6;

	assign ac1 = pca_q[15:0];
	assign ac2 = pca_q[31:16];
	assign ac3 = pca_q[47:32];
	assign ac4 = pca_q[63:48];
	assign ac5 = tc_q[15:0];
	assign ac6 = tc_q[31:16];
	assign mc  = tc_q[47:32];
	assign md  = tc_q[63:48];
	assign b1  = pcb_q[15:0];
	assign b2  = pcb_q[31:16];

	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// valid bits
	logic                v_s1, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;
	logic                v_s13, v_s14;
	logic [DIV1_W:0]     d1v_s;
	logic [DIV2_W:0]     d2v_s;

	// payload
	logic signed [33:0]  prod_s1;
	logic [18:0]         up_s1;
	div1_t               div1_s [DIV1_W+1];
	div2_t               div2_s [DIV2_W+1];
	side_t               sd_s3, sd_s4, sd_s5, sd_s6, sd_s7, sd_s8, sd_s9, sd_s10, sd_s11;
	side_t               sd_s12, sd_s13, sd_s14;
	logic signed [28:0]  b5_s3;
	logic signed [28:0]  b6_s4;
	logic [55:0]         sqp_s5;
	logic signed [44:0]  a2b6_s5, a3b6_s5;
	logic [43:0]         sq_s6;
	logic signed [33:0]  x2b_s6;
	logic signed [31:0]  x1c_s6, x1c_s7, x1c_s8;
	logic signed [33:0]  x2b_s7, x2b_s8;
	logic signed [38:0]  b2hi_s7, b2lo_s7, b1hi_s7, b1lo_s7;
	logic signed [48:0]  x1b_s8;
	logic signed [44:0]  x2c_s8;
	logic signed [49:0]  x3b_s9;
	logic signed [45:0]  x3c_s9;
	logic [31:0]         b3_s10, lo_s10;
	logic [16:0]         b4_s11, b4_s12;
	logic [31:0]         b7a_s11, b7_s12;
	logic [18:0]         p_s13, p_s14;
	logic                big_s13, big_s14;
	logic [21:0]         sq2_s13;
	logic [31:0]         m2_s13;
	logic [17:0]         x1p_s14;
	logic [15:0]         x2m_s14;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pca_q <= '0;
			tc_q  <= '0;
			pcb_q <= '0;
			oss_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PCOEF_A: pca_q <= cfg_data;
				REG_TCOEF:   tc_q  <= cfg_data;
				REG_PCOEF_B: pcb_q <= cfg_data[31:0];
				REG_OSS:     oss_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			d1v_s     <= '0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			v_s7      <= 1'b0;
			v_s8      <= 1'b0;
			v_s9      <= 1'b0;
			v_s10     <= 1'b0;
			v_s11     <= 1'b0;
			v_s12     <= 1'b0;
			d2v_s     <= '0;
			v_s13     <= 1'b0;
			v_s14     <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1      <= in_valid;
			d1v_s     <= {d1v_s[DIV1_W-1:0], v_s1};
			v_s3      <= d1v_s[DIV1_W];
			v_s4      <= v_s3;
			v_s5      <= v_s4;
			v_s6      <= v_s5;
			v_s7      <= v_s6;
			v_s8      <= v_s7;
			v_s9      <= v_s8;
			v_s10     <= v_s9;
			v_s11     <= v_s10;
			v_s12     <= v_s11;
			d2v_s     <= {d2v_s[DIV2_W-1:0], v_s12};
			v_s13     <= d2v_s[DIV2_W];
			v_s14     <= v_s13;
			out_valid <= v_s14;
		end
	end

	// stage 1: (UT - AC6) * AC5
	logic signed [16:0] utd;
	assign utd = $signed({1'b0, in_data.raw_temperature}) - $signed({1'b0, ac6});

	// divider 1 load
	logic signed [17:0] x1t;
	logic signed [18:0] den1;
	logic signed [26:0] num1;
	div1_t              d1_ld;
	always_comb begin
		x1t  = 18'(trunc_shr(64'(prod_s1), 6'd15));
		den1 = 19'(x1t) + 19'(md);
		num1 = 27'(mc) <<< 11;
		d1_ld        = '0;
		d1_ld.quo    = num1[26] ? 27'(-num1) : 27'(num1);
		d1_ld.dvs    = den1[18] ? 18'(-den1) : 18'(den1);
		d1_ld.neg    = num1[26] ^ den1[18];
		d1_ld.x1     = x1t;
		d1_ld.sd.up  = up_s1;
		d1_ld.sd.fault = (den1 == '0);
	end

	// stage 3: B5
	logic signed [27:0] x2t;
	assign x2t = div1_s[DIV1_W].neg ? -$signed({1'b0, div1_s[DIV1_W].quo})
		: $signed({1'b0, div1_s[DIV1_W].quo});

	// stage 4: temperature and B6
	logic signed [24:0] t_full;
	logic signed [16:0] t_sat;
	side_t              sd4_d;
	always_comb begin
		t_full = 25'(trunc_shr(64'(b5_s3) + 64'sd8, 6'd4));
		if (t_full > 25'(T_MAX))
			t_sat = 17'(T_MAX);
		else if (t_full < 25'(T_MIN))
			t_sat = 17'(T_MIN);
		else
			t_sat = 17'(t_full);
		sd4_d   = sd_s3;
		sd4_d.t = t_sat;
	end

	// stage 8: recombine partial products of B2*SQ and B1*SQ
	logic signed [60:0] b2sq, b1sq;
	assign b2sq = (61'(b2hi_s7) <<< 22) + 61'(b2lo_s7);
	assign b1sq = (61'(b1hi_s7) <<< 22) + 61'(b1lo_s7);

	// stage 10: B3 and X3 + 32768
	logic signed [63:0] b3_num;
	logic signed [43:0] x3c;
	assign b3_num = ((64'(ac1) <<< 2) + 64'(x3b_s9)) <<< oss_q;
	assign x3c    = 44'(trunc_shr(64'(x3c_s9), 6'd2));

	// stage 11 and 12 products
	logic [47:0] b4p, b7p;
	logic [15:0] p_scale;
	assign b4p     = ac4 * lo_s10;
	assign p_scale = 16'(P_SCALE >> oss_q);
	assign b7p     = b7a_s11 * p_scale;

	// divider 2 load: take 2*B7 / B4, or (B7 / B4) * 2 when B7 has its top bit set
	div2_t d2_ld;
	always_comb begin
		d2_ld          = '0;
		d2_ld.dbl      = b7_s12[31];
		d2_ld.quo      = b7_s12[31] ? b7_s12 : {b7_s12[30:0], 1'b0};
		d2_ld.dvs      = b4_s12;
		d2_ld.sd       = sd_s12;
		d2_ld.sd.fault = sd_s12.fault || (b4_s12 == '0);
	end

	// stage 13: quotient; anything at or above 2**19 saturates the result
	logic [32:0] q;
	assign q = div2_s[DIV2_W].dbl ? {div2_s[DIV2_W].quo, 1'b0}
		: {1'b0, div2_s[DIV2_W].quo};

	// output stage
	logic [33:0]        x1p_full;
	logic signed [19:0] corr;
	logic signed [20:0] pf;
	out_t               res;
	assign x1p_full = sq2_s13 * 12'(K_SQ);
	always_comb begin
		corr = $signed({2'b0, x1p_s14}) - $signed({4'b0, x2m_s14}) + 20'(K_OFS);
		pf   = $signed({2'b0, p_s14}) + 21'(trunc_shr(64'(corr), 6'd4));
		res  = '0;
		if (!sd_s14.fault) begin
			res.temperature_tenths = sd_s14.t;
			if (big_s14 || pf > 21'(P_MAX))
				res.pressure_pa = 18'(P_MAX);
			else if (pf < 0)
				res.pressure_pa = '0;
			else
				res.pressure_pa = 18'(pf);
		end else begin
			res.divide_fault = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= 34'(utd) * $signed({1'b0, ac5});
			up_s1   <= 19'(in_data.raw_pressure >> (4'd8 - {2'b0, oss_q}));

			div1_s[0] <= d1_ld;
			for (int i = 0; i < DIV1_W; i++)
				div1_s[i+1] <= div1_step(div1_s[i]);

			b5_s3 <= 29'(div1_s[DIV1_W].x1) + 29'(x2t);
			sd_s3 <= div1_s[DIV1_W].sd;

			b6_s4   <= b5_s3 - 29'(B6_OFFSET);
			sd_s4   <= sd4_d;

			sqp_s5  <= 56'(b6_s4 * b6_s4);
			a2b6_s5 <= 45'(ac2) * 45'(b6_s4);
			a3b6_s5 <= 45'(ac3) * 45'(b6_s4);
			sd_s5   <= sd_s4;

			sq_s6  <= sqp_s5[55:12];
			x2b_s6 <= 34'(trunc_shr(64'(a2b6_s5), 6'd11));
			x1c_s6 <= 32'(trunc_shr(64'(a3b6_s5), 6'd13));
			sd_s6  <= sd_s5;

			// split SQ into two 22-bit halves to keep the multipliers narrow
			b2hi_s7 <= b2 * $signed({1'b0, sq_s6[43:22]});
			b2lo_s7 <= b2 * $signed({1'b0, sq_s6[21:0]});
			b1hi_s7 <= b1 * $signed({1'b0, sq_s6[43:22]});
			b1lo_s7 <= b1 * $signed({1'b0, sq_s6[21:0]});
			x2b_s7  <= x2b_s6;
			x1c_s7  <= x1c_s6;
			sd_s7   <= sd_s6;

			x1b_s8 <= 49'(trunc_shr(64'(b2sq), 6'd11));
			x2c_s8 <= 45'(trunc_shr(64'(b1sq), 6'd16));
			x2b_s8 <= x2b_s7;
			x1c_s8 <= x1c_s7;
			sd_s8  <= sd_s7;

			x3b_s9 <= 50'(x1b_s8) + 50'(x2b_s8);
			x3c_s9 <= 46'(x1c_s8) + 46'(x2c_s8) + 46'sd2;
			sd_s9  <= sd_s8;

			b3_s10 <= 32'(trunc_shr(b3_num + 64'sd2, 6'd2));
			lo_s10 <= 32'(x3c + 44'(X3_OFFSET));
			sd_s10 <= sd_s9;

			b4_s11  <= b4p[31:15];
			b7a_s11 <= {13'b0, sd_s10.up} - b3_s10;
			sd_s11  <= sd_s10;

			b4_s12 <= b4_s11;
			b7_s12 <= b7p[31:0];
			sd_s12 <= sd_s11;

			div2_s[0] <= d2_ld;
			for (int j = 0; j < DIV2_W; j++)
				div2_s[j+1] <= div2_step(div2_s[j]);

			big_s13 <= |q[32:19];
			p_s13   <= q[18:0];
			sq2_s13 <= q[18:8] * q[18:8];
			m2_s13  <= q[18:0] * 13'(K_LIN);
			sd_s13  <= div2_s[DIV2_W].sd;

			x1p_s14 <= x1p_full[33:16];
			x2m_s14 <= m2_s13[31:16];
			p_s14   <= p_s13;
			big_s14 <= big_s13;
			sd_s14  <= sd_s13;

			out_data <= res;
		end
	end

	logic [DIV1_W+DIV2_W+15:0] vld_all;
	assign vld_all = {v_s1, d1v_s, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11,
		v_s12, d2v_s, v_s13, v_s14, out_valid};

	`BPC_ASSERT_IMPL(a_fault_zero, out_valid && out_data.divide_fault, out_data.temperature_tenths == '0 && out_data.pressure_pa == '0, "fault item carries nonzero results")
	`BPC_ASSERT_NEXT(a_stall_hold, !adv, $stable(vld_all), "pipeline moved while stalled")
	`BPC_ASSERT_NEXT(a_enter, in_valid && in_ready, v_s1, "accepted item did not enter stage one")

endmodule
